/* design/chr_pkg.sv */
// Package for the consistent-hash ring lookup block.
// Holds item structs, opcode and status codes, and the cell broadcast types.
// No dependencies; used by chr_cell and consistent_hash_ring_lookup_top.
`default_nettype none

package chr_pkg;

    // Default number of ring slots (virtual nodes the table can hold).
    localparam int unsigned RING_SLOTS_DEF = 512;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned OWNER_W = 4;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned ST_W    = 3;

    // Opcodes of an input item.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Status codes of a result item.
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP    = 3'd1;
    localparam logic [ST_W-1:0] ST_ABSENT = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [POS_W-1:0]   ring_point;
        logic [OWNER_W-1:0] server_id;
    } chr_in_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner_id;
        logic [ST_W-1:0]    status;
    } chr_out_t;

    // One ring entry held by a cell.
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [OWNER_W-1:0] owner;
    } chr_entry_t;

    // Table update applied by every cell in the apply cycle.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INS,
        ACT_REM
    } chr_act_t;

    // Command broadcast from the controller to the row of cells.
    typedef struct packed {
        logic               sample;
        logic               lookup;
        chr_act_t           act;
        logic [POS_W-1:0]   point;
        logic [OWNER_W-1:0] sid;
    } chr_bcast_t;

endpackage

`default_nettype wire

/* design/chr_cell.sv */
// One cell of the sorted ring: holds one entry and its compare flags.
// Shifts toward its right or left neighbor on insert or remove.
// Depends on chr_pkg.
`default_nettype none

module chr_cell
    import chr_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire chr_bcast_t       bcast,
    input  wire logic [CNT_W-1:0] count,
    input  wire chr_entry_t       left_entry,
    input  wire logic             left_flag,
    input  wire chr_entry_t       right_entry,
    output chr_entry_t            entry,
    output logic                  flag,
    output logic                  match
);

    chr_entry_t entry_reg;
    chr_entry_t entry_next;
    logic       flag_reg;
    logic       flag_next;
    logic       match_reg;
    logic       match_next;
    logic       valid;
    logic       gt;
    logic       eq;

    // The cell holds a live entry when its index is below the node count.
    assign valid = (count > CNT_W'(INDEX));
    assign gt    = (entry_reg.position > bcast.point);
    assign eq    = (entry_reg.position == bcast.point);

    // A lookup flags live entries strictly above the hash. Insert and remove
    // flag entries at or above the point, with empty cells counting as above.
    always_comb
    begin
        if (bcast.lookup)
        begin
            flag_next = valid & gt;
        end
        else
        begin
            flag_next = ~valid | gt | eq;
        end
        match_next = valid & eq;
    end

    // Compare flags are captured when an item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (bcast.sample)
        begin
            flag_reg  <= flag_next;
            match_reg <= match_next;
        end
    end

    // Insert opens a gap at the first flagged cell; remove closes it.
    always_comb
    begin
        entry_next = entry_reg;
        case (bcast.act)
            ACT_INS:
            begin
                if (flag_reg)
                begin
                    if (left_flag)
                    begin
                        entry_next = left_entry;
                    end
                    else
                    begin
                        entry_next.position = bcast.point;
                        entry_next.owner    = bcast.sid;
                    end
                end
            end
            ACT_REM:
            begin
                if (flag_reg)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry payload needs no reset; the node count marks what is live.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

/* design/consistent_hash_ring_lookup_top.sv */
// Consistent-hash ring lookup with virtual nodes: controller and cell row.
// Depends on chr_pkg and chr_cell.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one item: an
//   insert, remove or lookup of a precomputed 32-bit ring point. The output
//   channel (out_valid, out_ready, out_data) returns one result item per
//   input item, in order, carrying the owner id and a status code.
//   Every item passes a compare step and a shift step: in the cycle it is accepted all cells
//   compare their entry with the point in parallel and register flags; in
//   the next cycle the row shifts on insert or remove, the lookup owner is
//   picked from the one-hot flag edge, and the result is registered. No
//   new item is taken while the held item is being applied, set by the
//   compare-then-shift pass through the cell row.
//   A result waits in the output register while the receiver stalls; the
//   next item is taken at the edge at which that result leaves.
//   Reset empties the ring (node count zero) and clears the output channel;
//   no clearing pass is needed.
`default_nettype none

module consistent_hash_ring_lookup_top
    import chr_pkg::*;
#(
    parameter int unsigned RING_SLOTS = RING_SLOTS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire chr_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output chr_out_t      out_data
);

    localparam int unsigned CNT_W = $clog2(RING_SLOTS + 1);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    chr_in_t          cmd_reg;
    chr_in_t          cmd_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    chr_out_t         out_data_reg;
    chr_out_t         out_data_next;

    chr_bcast_t             bcast;
    chr_act_t               act;
    logic                   accept;
    chr_entry_t             entries [RING_SLOTS];
    logic [RING_SLOTS-1:0]  flags;
    logic [RING_SLOTS-1:0]  hit_flags;
    logic [OWNER_W-1:0]     sel_owner [RING_SLOTS];
    logic [OWNER_W-1:0]     hit_owner;
    logic                   found;
    logic                   any_above;

    // Input is taken only between items and when the output slot frees up.
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Broadcast: the incoming point while sampling, the held point on apply.
    always_comb
    begin
        bcast.sample = accept;
        bcast.lookup = (in_data.opcode == OP_LOOKUP);
        bcast.act    = act;
        bcast.point  = (state_reg == S_IDLE) ? in_data.ring_point : cmd_reg.ring_point;
        bcast.sid    = cmd_reg.server_id;
    end

    // Row of cells, each wired to its two neighbors.
    for (genvar i = 0; i < RING_SLOTS; i++)
    begin : g_cell
        chr_entry_t left_entry;
        chr_entry_t right_entry;
        logic       left_flag;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_flag  = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = entries[i-1];
            assign left_flag  = flags[i-1];
        end

        if (i == RING_SLOTS - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_body
            assign right_entry = entries[i+1];
        end

        chr_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .bcast       (bcast),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_flag   (left_flag),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .flag        (flags[i]),
            .match       (hit_flags[i])
        );

        // Only the first flagged cell passes its owner on a lookup.
        assign sel_owner[i] = (flags[i] && !left_flag) ? entries[i].owner : '0;
    end

    // Gather the single selected owner and the match result.
    always_comb
    begin
        hit_owner = '0;
        for (int unsigned k = 0; k < RING_SLOTS; k++)
        begin
            hit_owner = hit_owner | sel_owner[k];
        end
        found     = |hit_flags;
        any_above = |flags;
    end

    // Decide the table update and the result in the apply cycle.
    always_comb
    begin
        act           = ACT_NONE;
        count_next    = count_reg;
        out_data_next = out_data_reg;
        if (state_reg == S_APPLY)
        begin
            out_data_next.owner_id = '0;
            out_data_next.status   = ST_OK;
            case (cmd_reg.opcode)
                OP_INSERT:
                begin
                    if (found)
                    begin
                        out_data_next.status = ST_DUP;
                    end
                    else if (count_reg == CNT_W'(RING_SLOTS))
                    begin
                        out_data_next.status = ST_FULL;
                    end
                    else
                    begin
                        act        = ACT_INS;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (found)
                    begin
                        act        = ACT_REM;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        out_data_next.status = ST_ABSENT;
                    end
                end
                OP_LOOKUP:
                begin
                    if (count_reg == '0)
                    begin
                        out_data_next.status = ST_EMPTY;
                    end
                    else if (any_above)
                    begin
                        out_data_next.owner_id = hit_owner;
                    end
                    else
                    begin
                        // Hash at or past the largest position wraps to the smallest.
                        out_data_next.owner_id = entries[0].owner;
                    end
                end
                default:
                begin
                    out_data_next.status = ST_OK;
                end
            endcase
        end
    end

    // Next state, held command and output valid.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_data;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The node count never exceeds the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_SLOTS))
        else $error("node count above ring size");

    // An accepted item is applied in the following cycle.
    a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_APPLY))
        else $error("accepted item not applied next cycle");

    // The apply cycle always leaves a result waiting.
    a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> out_valid_reg)
        else $error("apply cycle produced no result");

    // The node count changes only as the result of an apply cycle.
    a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == S_APPLY))
        else $error("node count changed outside an apply cycle");
`endif

endmodule

`default_nettype wire
